[rtl/thermal_interlock_fan_control_macros.svh]
// Assertion macros shared by the thermal interlock RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef THERMAL_INTERLOCK_FAN_CONTROL_MACROS_SVH
`define THERMAL_INTERLOCK_FAN_CONTROL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TIFC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tifc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TIFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tifc: next-cycle check failed");

`endif

[rtl/tifc_pkg.sv]
// Package for the thermal interlock and fan controller: payload types,
// register indexes and controller/datapath command and status structs. No dependencies.
package tifc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_W      = 20;  // fan mapping numerator, signed
  localparam int unsigned DEN_W      = 8;   // divisor magnitude

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAN_ON   = 3'd0,
    REG_CRITICAL = 3'd1,
    REG_FAN_MIN  = 3'd2,
    REG_FAN_MAX  = 3'd3,
    REG_HOLD_MS  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic               kind;
    logic signed [11:0] temp_driver;
    logic signed [11:0] temp_head;
    logic signed [11:0] temp_inv_pos;
    logic signed [11:0] temp_inv_neg;
    logic               button_pressed;
    logic [15:0]        elapsed_ms;
  } tifc_in_t;

  typedef struct packed {
    logic [7:0]  fan_level;
    logic        locked;
    logic        laser_enabled;
    logic        over_temp;
    logic [15:0] hold_ms_left;
  } tifc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       conv;
    logic [1:0] idx;
    logic       mul1;
    logic       mul2;
    logic       div_start;
    logic       upd;
  } tifc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } tifc_status_t;

endpackage

[rtl/thermal_interlock_fan_control.sv]
// Top level of the thermal interlock and fan controller.
// Depends on tifc_pkg, tifc_ctrl, tifc_dp (which holds tifc_div).
//
//   channel  signals                          direction  transfer when
//   in       in_valid, in_ready, in_data      sink       in_valid && in_ready
//   out      out_valid, out_ready, out_data   source     out_valid && out_ready
//   cfg      cfg_valid, cfg_ready, cfg_index,  sink       cfg_valid && cfg_ready
//            cfg_data
//
// One item at a time. An item whose fan level is interpolated also passes
// through the 20-step serial divider and so takes longer than one that needs
// no divide. rst (synchronous) restores register defaults, lock and supply on,
// timer and fan level zero. A held result does not block the next input
// transfer; the update waits for the result register.
module thermal_interlock_fan_control (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tifc_pkg::tifc_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tifc_pkg::tifc_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tifc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tifc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tifc_pkg::tifc_cmd_t    cmd;
  tifc_pkg::tifc_status_t status;

  assign cfg_ready = 1'b1;

  tifc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tifc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[rtl/tifc_div.sv]
// Restoring divider for the fan mapping, one quotient bit per cycle.
// Depends on tifc_pkg for operand widths.
module tifc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tifc_pkg::NUM_W-1:0]  dividend,
  input  logic [tifc_pkg::DEN_W-1:0]  divisor,
  output logic                        done,
  output logic [tifc_pkg::NUM_W-1:0]  quotient
);

  localparam int unsigned QW    = tifc_pkg::NUM_W;
  localparam int unsigned DW    = tifc_pkg::DEN_W;
  localparam int unsigned CNT_W = $clog2(QW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    rem_next;
  logic [QW-1:0]    qr;
  logic [DW:0]      trial;
  logic             ge;

  // trial subtract of the shifted remainder
  always_comb begin
    trial    = {rem, qr[QW-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
  end

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qr  <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      qr  <= {qr[QW-2:0], ge};
    end
  end

  assign quotient = qr;

endmodule

[rtl/tifc_dp.sv]
// Datapath: config registers, temperature conversion, fan mapping, interlock state.
// Depends on tifc_pkg and tifc_div.
module tifc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  tifc_pkg::tifc_cmd_t               cmd,
  output tifc_pkg::tifc_status_t            status,
  input  tifc_pkg::tifc_in_t                in_data,
  output tifc_pkg::tifc_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [tifc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tifc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned NW = tifc_pkg::NUM_W;
  localparam int unsigned DW = tifc_pkg::DEN_W;
  // x/10 == (x*1639) >> 14 for 0 <= x <= 2048
  localparam logic [22:0] DEG_RECIP = 23'd1639;

  // config registers
  logic [7:0]  fan_on;
  logic [7:0]  fan_crit;
  logic [7:0]  fan_min;
  logic [7:0]  fan_max;
  logic [15:0] hold_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_on   <= 8'd32;
      fan_crit <= 8'd60;
      fan_min  <= 8'd10;
      fan_max  <= 8'd150;
      hold_ms  <= 16'd500;
    end else if (cfg_we) begin
      unique case (tifc_pkg::cfg_reg_t'(cfg_index))
        tifc_pkg::REG_FAN_ON:   fan_on   <= cfg_data[7:0];
        tifc_pkg::REG_CRITICAL: fan_crit <= cfg_data[7:0];
        tifc_pkg::REG_FAN_MIN:  fan_min  <= cfg_data[7:0];
        tifc_pkg::REG_FAN_MAX:  fan_max  <= cfg_data[7:0];
        tifc_pkg::REG_HOLD_MS:  hold_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // item register
  tifc_pkg::tifc_in_t item;

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
  end

  // one temperature per cycle: truncate tenths toward zero
  logic signed [11:0] temp_sel;
  logic [11:0]        temp_u;
  logic               raw_neg;
  logic [11:0]        raw_abs;
  logic [22:0]        deg_prod;
  logic [8:0]         mag9;
  logic signed [8:0]  deg;
  logic signed [8:0]  crit_s;
  logic signed [8:0]  on_s;

  always_comb begin
    case (cmd.idx)
      2'd0:    temp_sel = item.temp_driver;
      2'd1:    temp_sel = item.temp_head;
      2'd2:    temp_sel = item.temp_inv_pos;
      default: temp_sel = item.temp_inv_neg;
    endcase
    temp_u   = temp_sel;
    raw_neg  = temp_u[11];
    raw_abs  = raw_neg ? (~temp_u + 12'd1) : temp_u;
    deg_prod = 23'(raw_abs) * DEG_RECIP;
    mag9     = {1'b0, deg_prod[21:14]};
    deg      = raw_neg ? $signed(~mag9 + 9'd1) : $signed(mag9);
    crit_s   = $signed({1'b0, fan_crit});
    on_s     = $signed({1'b0, fan_on});
  end

  // hottest temperature and over-temperature flag
  logic signed [8:0] hottest;
  logic              over;

  always_ff @(posedge clk) begin
    if (cmd.conv) begin
      if (cmd.idx == 2'd0) begin
        hottest <= deg;
        over    <= deg > crit_s;
      end else begin
        if (deg > hottest) hottest <= deg;
        over <= over | (deg > crit_s);
      end
    end
  end

  // fan mapping operands
  logic              hot_gt_on;
  logic signed [8:0] den;
  logic signed [9:0] diff;
  logic signed [8:0] span;
  logic signed [8:0] lo_s;
  logic signed [18:0] p1;
  logic signed [17:0] p2;
  logic signed [18:0] prod1;
  logic signed [NW-1:0] num;

  always_comb begin
    hot_gt_on = hottest > on_s;
    den       = crit_s - on_s;
    diff      = $signed({hottest[8], hottest}) - $signed({2'b00, fan_on});
    span      = $signed({1'b0, fan_max}) - $signed({1'b0, fan_min});
    lo_s      = $signed({1'b0, fan_min});
    p1        = 19'(diff) * 19'(span);
    p2        = 18'(lo_s) * 18'(den);
  end

  // two multiply stages, registered between them
  always_ff @(posedge clk) begin
    if (cmd.mul1) prod1 <= p1;
    if (cmd.mul2) num   <= NW'(prod1) + NW'(p2);
  end

  // magnitudes into the divider
  logic [NW-1:0] num_u;
  logic [NW-1:0] num_abs;
  logic [8:0]    den_u;
  logic [8:0]    den_neg;
  logic [DW-1:0] den_abs;
  logic          div_done;
  logic [NW-1:0] quot;

  always_comb begin
    num_u   = num;
    num_abs = num_u[NW-1] ? (~num_u + 1'b1) : num_u;
    den_u   = den;
    den_neg = ~den_u + 9'd1;
    den_abs = den_u[8] ? den_neg[DW-1:0] : den_u[DW-1:0];
  end

  tifc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (num_abs),
    .divisor  (den_abs),
    .done     (div_done),
    .quotient (quot)
  );

  assign status.need_div = (item.kind == tifc_pkg::KIND_TICK) && hot_gt_on && (den != '0);
  assign status.div_done = div_done;

  // clamp and fan level selection
  logic       res_neg;
  logic [7:0] fan_map;
  logic [7:0] fan_sel;

  always_comb begin
    res_neg = num[NW-1] ^ den[8];
    if (res_neg)                fan_map = 8'd0;
    else if (quot > NW'(255))   fan_map = 8'd255;
    else                        fan_map = quot[7:0];
    if (!hot_gt_on)             fan_sel = 8'd0;
    else if (den == '0)         fan_sel = fan_max;
    else                        fan_sel = fan_map;
  end

  // interlock state
  logic        lock;
  logic        supply;
  logic [15:0] hold;
  logic [7:0]  fan_level;
  logic        lock_next;
  logic        supply_next;
  logic [15:0] hold_next;
  logic [7:0]  fan_level_next;

  always_comb begin
    lock_next      = lock;
    supply_next    = supply;
    hold_next      = hold;
    fan_level_next = fan_level;
    if (item.kind == tifc_pkg::KIND_TICK) begin
      fan_level_next = fan_sel;
      if (hold != '0) begin
        hold_next = (hold >= item.elapsed_ms) ? hold - item.elapsed_ms : '0;
        if (!item.button_pressed) lock_next = 1'b0;
      end else begin
        lock_next = lock | item.button_pressed;
        if (lock_next) supply_next = 1'b0;
      end
    end else if (!over) begin
      hold_next   = hold_ms;
      supply_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock      <= 1'b1;
      supply    <= 1'b1;
      hold      <= '0;
      fan_level <= '0;
    end else if (cmd.upd) begin
      lock      <= lock_next;
      supply    <= supply_next;
      hold      <= hold_next;
      fan_level <= fan_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_data.fan_level     <= fan_level_next;
      out_data.locked        <= lock_next;
      out_data.laser_enabled <= supply_next;
      out_data.over_temp     <= over;
      out_data.hold_ms_left  <= hold_next;
    end
  end

endmodule

[rtl/tifc_ctrl.sv]
// Controller state machine: sequences conversion, multiplies, divide and update.
// Depends on tifc_pkg and thermal_interlock_fan_control_macros.svh.
`include "thermal_interlock_fan_control_macros.svh"

module tifc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  tifc_pkg::tifc_status_t status,
  output tifc_pkg::tifc_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CONV   = 8'b0000_0010,
    S_CHK    = 8'b0000_0100,
    S_MUL1   = 8'b0000_1000,
    S_MUL2   = 8'b0001_0000,
    S_DSTART = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_UPD    = 8'b1000_0000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] idx;
  logic       upd_fire;

  assign in_ready = (state == S_IDLE);
  // update waits for the result register to be free or drained this cycle
  assign upd_fire = (state == S_UPD) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_CONV;
      S_CONV:   if (idx == 2'd3) state_next = S_CHK;
      S_CHK:    state_next = status.need_div ? S_MUL1 : S_UPD;
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV:    if (status.div_done) state_next = S_UPD;
      S_UPD:    if (upd_fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CONV) idx <= idx + 2'd1;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (upd_fire)  out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  // datapath commands
  always_comb begin
    cmd.load      = in_valid && in_ready;
    cmd.conv      = (state == S_CONV);
    cmd.idx       = idx;
    cmd.mul1      = (state == S_MUL1);
    cmd.mul2      = (state == S_MUL2);
    cmd.div_start = (state == S_DSTART);
    cmd.upd       = upd_fire;
  end

  `TIFC_ASSERT_NEXT(a_accept_to_conv, clk, rst, in_valid && in_ready, state == S_CONV && idx == 2'd0)
  `TIFC_ASSERT_NEXT(a_upd_sets_valid, clk, rst, upd_fire, out_valid)
  `TIFC_ASSERT_NOW(a_div_done_in_div, clk, rst, status.div_done, state == S_DIV)
  `TIFC_ASSERT_NEXT(a_conv_four_steps, clk, rst, state == S_CONV && idx == 2'd3, state == S_CHK)

endmodule
